[rtl/ssnf_pkg.sv]
// Package for the seven-segment number frame core.
// Holds shared constants, the segment table, and controller/datapath types.
// No dependencies.
`default_nettype none

package ssnf_pkg;

    // Number of digit positions on the display.
    localparam int DIGIT_POSITIONS = 4;
    localparam int CNT_W = $clog2(DIGIT_POSITIONS + 1);
    localparam int IDX_W = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;

    // Display command bytes and special segment patterns.
    localparam logic [7:0] CMD_DATA_MODE = 8'h40;
    localparam logic [7:0] CMD_ADDRESS   = 8'hC0;
    localparam logic [7:0] CMD_CONTROL   = 8'h80;
    localparam logic [7:0] SEG_MINUS     = 8'b0100_0000;
    localparam logic [7:0] SEG_DOT       = 8'h80;
    localparam logic [7:0] SEG_BLANK     = 8'h00;

    // Reciprocal of ten for 16-bit operands: x / 10 == (x * 52429) >> 19.
    localparam logic [16:0] RECIP_TEN = 17'd52429;

    // Configuration register indexes.
    localparam logic [7:0] CFG_BRIGHTNESS = 8'd0;
    localparam logic [7:0] CFG_DISPLAY_ON = 8'd1;

    // Segment patterns for hex digits, bit order DP G F E D C B A.
    localparam logic [7:0] SEG_TABLE [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CMD,
        ST_ADDR,
        ST_DIGIT,
        ST_CTRL
    } ctrl_state_t;

    typedef enum logic [1:0] {
        KIND_DATA_MODE,
        KIND_ADDRESS,
        KIND_DIGIT,
        KIND_CONTROL
    } byte_kind_t;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       emit;
        byte_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic conv_last;
        logic dig_last;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [2:0] brightness;
        logic       display_on;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/ssnf_ctrl.sv]
// Controller state machine for the seven-segment number frame core.
// Sequences load, digit conversion and byte emission. Depends on ssnf_pkg.
`default_nettype none

module ssnf_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  ssnf_pkg::dp_status_t status,
    output ssnf_pkg::dp_cmd_t   cmd
);
    import ssnf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (status.count_zero || status.conv_last)
                begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                if (status.out_free)
                begin
                    state_next = status.count_zero ? ST_CTRL : ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free && status.dig_last)
                begin
                    state_next = ST_CTRL;
                end
            end
            ST_CTRL:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.emit      = 1'b0;
        cmd.kind      = KIND_DATA_MODE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONV:
            begin
                cmd.conv_step = !status.count_zero;
            end
            ST_CMD:
            begin
                cmd.emit = status.out_free;
                cmd.kind = KIND_DATA_MODE;
            end
            ST_ADDR:
            begin
                cmd.emit = status.out_free;
                cmd.kind = KIND_ADDRESS;
            end
            ST_DIGIT:
            begin
                cmd.emit = status.out_free;
                cmd.kind = KIND_DIGIT;
            end
            ST_CTRL:
            begin
                cmd.emit = status.out_free;
                cmd.kind = KIND_CONTROL;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/ssnf_datapath.sv]
// Datapath for the seven-segment number frame core: digit conversion,
// segment encoding, digit store and output register. Depends on ssnf_pkg.
`default_nettype none

module ssnf_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire  [31:0]          in_data,
    input  ssnf_pkg::cfg_t       cfg,
    input  ssnf_pkg::dp_cmd_t    cmd,
    output ssnf_pkg::dp_status_t status,
    input  wire                  out_ready,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 out_start,
    output logic                 out_stop,
    output logic                 out_last
);
    import ssnf_pkg::*;

    // Unpacked input fields.
    logic [15:0] in_magnitude;
    logic        in_negative;
    logic        in_hex;
    logic [7:0]  in_dots;
    logic        in_lz;
    logic [2:0]  in_count;
    logic [1:0]  in_pos;
    logic [CNT_W-1:0] cnt_in;

    assign in_magnitude = in_data[15:0];
    assign in_negative  = in_data[16];
    assign in_hex       = in_data[17];
    assign in_dots      = in_data[25:18];
    assign in_lz        = in_data[26];
    assign in_count     = in_data[29:27];
    assign in_pos       = in_data[31:30];

    assign cnt_in = (int'(in_count) > DIGIT_POSITIONS) ? CNT_W'(DIGIT_POSITIONS)
                                                      : CNT_W'(in_count);

    // Item registers.
    logic [15:0]                num_reg;
    logic                       hex_reg;
    logic                       neg_reg;
    logic                       lz_reg;
    logic                       zs_reg;
    logic [DIGIT_POSITIONS-1:0] dot_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [1:0]                 pos_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           ptr_reg;
    logic [7:0]                 dig_reg [DIGIT_POSITIONS];

    // Output register.
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       stop_reg;
    logic       last_reg;

    // One conversion step: split off the rightmost digit.
    logic [31:0] prod;
    logic [15:0] q_ten;
    logic [15:0] rem_ten;
    logic [3:0]  digit;
    logic [15:0] quot;
    logic        num_zero;
    logic        at_right;
    logic        minus_used;
    logic [7:0]  step_byte;

    always_comb
    begin
        prod     = 32'(num_reg) * 32'(RECIP_TEN);
        q_ten    = {3'b000, prod[31:19]};
        rem_ten  = num_reg - ((q_ten << 3) + (q_ten << 1));
        digit    = hex_reg ? num_reg[3:0] : rem_ten[3:0];
        quot     = hex_reg ? {4'b0000, num_reg[15:4]} : q_ten;
        num_zero = (num_reg == 16'd0);
        at_right = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
        minus_used = !zs_reg && num_zero && neg_reg;
        if (zs_reg)
        begin
            step_byte = at_right ? SEG_TABLE[0] : SEG_BLANK;
        end
        else if (minus_used)
        begin
            step_byte = SEG_MINUS;
        end
        else if (num_zero && !lz_reg)
        begin
            step_byte = SEG_BLANK;
        end
        else
        begin
            step_byte = SEG_TABLE[digit];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg <= in_magnitude;
            hex_reg <= in_hex;
            neg_reg <= in_negative && !in_hex;
            lz_reg  <= in_lz;
            zs_reg  <= (in_magnitude == 16'd0) && !in_lz;
            cnt_reg <= cnt_in;
            pos_reg <= in_pos;
            idx_reg <= IDX_W'(cnt_in - CNT_W'(1));
            ptr_reg <= '0;
            // Dot of the first written digit sits in the top mask bit.
            for (int i = 0; i < DIGIT_POSITIONS; i++)
            begin
                dot_reg[i] <= in_dots[7 - i] && !((in_magnitude == 16'd0) && !in_lz);
            end
        end
        else
        begin
            if (cmd.conv_step)
            begin
                dig_reg[idx_reg] <= step_byte;
                num_reg          <= quot;
                idx_reg          <= idx_reg - IDX_W'(1);
                if (minus_used)
                begin
                    neg_reg <= 1'b0;
                end
            end
            if (cmd.emit && (cmd.kind == KIND_DIGIT))
            begin
                ptr_reg <= ptr_reg + IDX_W'(1);
            end
        end
    end

    logic dig_last;
    assign dig_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == cnt_reg);

    assign status.count_zero = (cnt_reg == '0);
    assign status.conv_last  = (idx_reg == '0);
    assign status.dig_last   = dig_last;
    assign status.out_free   = !valid_reg || out_ready;

    // Byte selection for the frame.
    logic [7:0] sel_byte;
    logic       sel_start;
    logic       sel_stop;
    logic       sel_last;

    always_comb
    begin
        sel_byte  = CMD_DATA_MODE;
        sel_start = 1'b1;
        sel_stop  = 1'b1;
        sel_last  = 1'b0;
        case (cmd.kind)
            KIND_DATA_MODE:
            begin
                sel_byte = CMD_DATA_MODE;
            end
            KIND_ADDRESS:
            begin
                sel_byte = CMD_ADDRESS | {6'b000000, pos_reg};
                sel_stop = (cnt_reg == '0);
            end
            KIND_DIGIT:
            begin
                sel_byte  = dig_reg[ptr_reg] | (dot_reg[ptr_reg] ? SEG_DOT : SEG_BLANK);
                sel_start = 1'b0;
                sel_stop  = dig_last;
            end
            KIND_CONTROL:
            begin
                sel_byte = CMD_CONTROL | {4'b0000, cfg.display_on, cfg.brightness};
                sel_last = 1'b1;
            end
            default:
            begin
                sel_byte = CMD_DATA_MODE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            byte_reg  <= sel_byte;
            start_reg <= sel_start;
            stop_reg  <= sel_stop;
            last_reg  <= sel_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_start = start_reg;
    assign out_stop  = stop_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

[rtl/seven_segment_number_frame_core.sv]
// After the transfer that delivers the number, the controller converts the digits in ST_CONV,
// one digit per cycle, and then presents the first frame byte from the output register.
// One number at a time, paced by the shared divide-by-base step and the single byte
// output register; a new number is taken only once the control byte is emitted.
// Reset is asynchronous, active low: control idles, brightness returns to 7, display on.
`default_nettype none

// Top level of the seven-segment number frame core. It holds the two
// configuration registers and joins the controller to the datapath.
// Every other part of the block lives in ssnf_ctrl and ssnf_datapath.
module seven_segment_number_frame_core (
    input  wire         clk,
    input  wire         rst_n,
    // Number input stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    // From bit 0: magnitude[15:0], negative, hex_mode, dot_mask[7:0],
    // show_zeros, digit_count[2:0], start_position[1:0].
    input  wire  [31:0] s_tdata,
    // Frame byte output stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    // From bit 0: frame_byte[7:0].
    output logic [7:0]  m_tdata,
    // From bit 0: start_before, stop_after.
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    // Configuration write channel.
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_index,
    input  wire  [7:0]  cfg_data
);
    import ssnf_pkg::*;

    // Configuration registers. Writes are always taken; an index that
    // names no register is accepted and ignored.
    logic [2:0] brightness_reg;
    logic       display_on_reg;
    cfg_t       cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 3'd7;
            display_on_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_BRIGHTNESS)
            begin
                brightness_reg <= cfg_data[2:0];
            end
            else if (cfg_index == CFG_DISPLAY_ON)
            begin
                display_on_reg <= cfg_data[0];
            end
        end
    end

    assign cfg.brightness = brightness_reg;
    assign cfg.display_on = display_on_reg;

    // The controller walks through conversion and then the frame bytes;
    // the datapath does the arithmetic and holds the output register.
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       out_start;
    logic       out_stop;

    ssnf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssnf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_start (out_start),
        .out_stop  (out_stop),
        .out_last  (m_tlast)
    );

    assign m_tuser = {out_stop, out_start};

`ifndef SYNTHESIS
    // Only one number is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a frame is in work");

    // The closing control byte always carries both start and stop.
    a_last_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == 2'b11))
        else $error("control byte without start and stop flags");

    // A byte the sink has not taken stays on the bus unchanged.
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("waiting frame byte changed before its transfer");

    // A new number is taken only once the frame's control byte is out.
    a_idle_after_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tvalid) |-> m_tlast)
        else $error("input accepted while frame bytes remain");
`endif

endmodule

`default_nettype wire
